@@ design/stt_pkg.sv @@
package stt_pkg;

    localparam int KEYWORD_REG_BITS = 64;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int FIELD_BITS       = 16;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_BITS    = 2;
    localparam int FIFO_COUNT_BITS  = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_KEYWORD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_KEYWORD = 2'd1;

    localparam logic [KEYWORD_REG_BITS-1:0] FIRST_KEYWORD_RESET  = 64'h0000_0000_0074_656C;
    localparam logic [KEYWORD_REG_BITS-1:0] SECOND_KEYWORD_RESET = 64'h0000_0000_0000_6E66;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_EOT        = 8'h00;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_RETURN     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_RPAREN     = 8'h29;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_COMMA      = 8'h2C;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE     = 8'h7D;

    typedef enum logic [3:0] {
        KIND_ILLEGAL   = 4'd0,
        KIND_EOF       = 4'd1,
        KIND_IDENT     = 4'd2,
        KIND_INT       = 4'd3,
        KIND_ASSIGN    = 4'd4,
        KIND_PLUS      = 4'd5,
        KIND_COMMA     = 4'd6,
        KIND_SEMICOLON = 4'd7,
        KIND_LPAREN    = 4'd8,
        KIND_RPAREN    = 4'd9,
        KIND_LBRACE    = 4'd10,
        KIND_RBRACE    = 4'd11,
        KIND_KW1       = 4'd12,
        KIND_KW2       = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } token_t;

    // Tokens raised by one accepted byte: none, one or two, first in order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_EQUALS:    k = KIND_ASSIGN;
            CHAR_PLUS:      k = KIND_PLUS;
            CHAR_COMMA:     k = KIND_COMMA;
            CHAR_SEMICOLON: k = KIND_SEMICOLON;
            CHAR_LPAREN:    k = KIND_LPAREN;
            CHAR_RPAREN:    k = KIND_RPAREN;
            CHAR_LBRACE:    k = KIND_LBRACE;
            CHAR_RBRACE:    k = KIND_RBRACE;
            default:        k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

@@ design/stt_scanner.sv @@
module stt_scanner #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_BYTES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [7:0]                           char_byte,
    input  logic                                 cfg_write,
    input  logic [stt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [stt_pkg::KEYWORD_REG_BITS-1:0] cfg_data,
    output stt_pkg::push_t                       push
);

    localparam int WINDOW_BITS = 8 * KEYWORD_BYTES;
    localparam int WLEN_BITS   = $clog2(KEYWORD_BYTES + 2);
    localparam logic [WLEN_BITS-1:0] WLEN_LIMIT = WLEN_BITS'(KEYWORD_BYTES);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [stt_pkg::KEYWORD_REG_BITS-1:0] first_kw_reg;
    logic [stt_pkg::KEYWORD_REG_BITS-1:0] second_kw_reg;

    stt_pkg::mode_t          mode_reg, mode_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [WINDOW_BITS-1:0]   window_reg, window_next;
    logic [WLEN_BITS-1:0]     wlen_reg, wlen_next;

    logic is_letter, is_digit, is_space, is_eot;
    logic cont_run, flush, single_emit;
    stt_pkg::kind_t run_kind;
    stt_pkg::token_t run_tok, single_tok;
    logic [stt_pkg::KEYWORD_REG_BITS-1:0] window_ext;

    function automatic logic [stt_pkg::FIELD_BITS-1:0] sat_field(
        input logic [POSITION_BITS-1:0] v
    );
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(stt_pkg::FIELD_MAX)) ? stt_pkg::FIELD_MAX : w[15:0];
    endfunction

    always_comb
    begin
        is_letter = char_byte inside {[stt_pkg::CHAR_LOWER_A:stt_pkg::CHAR_LOWER_Z],
                                      [stt_pkg::CHAR_UPPER_A:stt_pkg::CHAR_UPPER_Z],
                                      stt_pkg::CHAR_UNDERSCORE};
        is_digit  = char_byte inside {[stt_pkg::CHAR_ZERO:stt_pkg::CHAR_NINE]};
        is_space  = char_byte inside {stt_pkg::CHAR_SPACE, stt_pkg::CHAR_TAB,
                                      stt_pkg::CHAR_NEWLINE, stt_pkg::CHAR_RETURN};
        is_eot    = (char_byte == stt_pkg::CHAR_EOT);

        cont_run = ((mode_reg == stt_pkg::MODE_IDENT) && (is_letter || is_digit)) ||
                   ((mode_reg == stt_pkg::MODE_NUMBER) && is_digit);
        flush       = (mode_reg != stt_pkg::MODE_IDLE) && !cont_run;
        single_emit = !cont_run && (is_eot || !(is_space || is_letter || is_digit));

        // Keyword check only for identifiers that fitted in the window
        window_ext = stt_pkg::KEYWORD_REG_BITS'(window_reg);
        run_kind = stt_pkg::KIND_INT;
        if (mode_reg == stt_pkg::MODE_IDENT)
        begin
            run_kind = stt_pkg::KIND_IDENT;
            if (wlen_reg <= WLEN_LIMIT)
            begin
                if (window_ext == first_kw_reg)
                    run_kind = stt_pkg::KIND_KW1;
                else if (window_ext == second_kw_reg)
                    run_kind = stt_pkg::KIND_KW2;
            end
        end

        run_tok.kind   = run_kind;
        run_tok.start  = sat_field(begin_reg);
        run_tok.length = sat_field(pos_reg - begin_reg);
        run_tok.last   = !single_emit;

        single_tok.kind   = is_eot ? stt_pkg::KIND_EOF : stt_pkg::punct_kind(char_byte);
        single_tok.start  = sat_field(pos_reg);
        single_tok.length = is_eot ? '0 : stt_pkg::FIELD_BITS'(1);
        single_tok.last   = 1'b1;

        push.count  = accept ? (2'(flush) + 2'(single_emit)) : 2'd0;
        push.first  = flush ? run_tok : single_tok;
        push.second = single_tok;

        // Next scan state
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        window_next = window_reg;
        wlen_next   = wlen_reg;
        pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        if (is_eot)
            pos_next = '0;

        if (cont_run)
        begin
            if (mode_reg == stt_pkg::MODE_IDENT)
            begin
                for (int i = 0; i < KEYWORD_BYTES; i++)
                begin
                    if (wlen_reg == WLEN_BITS'(i))
                        window_next[i*8 +: 8] = char_byte;
                end
                if (wlen_reg <= WLEN_LIMIT)
                    wlen_next = wlen_reg + 1'b1;
            end
        end
        else
        begin
            mode_next   = stt_pkg::MODE_IDLE;
            window_next = '0;
            wlen_next   = '0;
            if (is_eot)
                begin_next = '0;
            else if (is_letter)
            begin
                mode_next   = stt_pkg::MODE_IDENT;
                begin_next  = pos_reg;
                window_next = WINDOW_BITS'(char_byte);
                wlen_next   = WLEN_BITS'(1);
            end
            else if (is_digit)
            begin
                mode_next  = stt_pkg::MODE_NUMBER;
                begin_next = pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_kw_reg  <= stt_pkg::FIRST_KEYWORD_RESET;
            second_kw_reg <= stt_pkg::SECOND_KEYWORD_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == stt_pkg::CFG_FIRST_KEYWORD)
                first_kw_reg <= cfg_data;
            else if (cfg_index == stt_pkg::CFG_SECOND_KEYWORD)
                second_kw_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            begin_reg  <= '0;
            pos_reg    <= '0;
            window_reg <= '0;
            wlen_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            begin_reg  <= begin_next;
            pos_reg    <= pos_next;
            window_reg <= window_next;
            wlen_reg   <= wlen_next;
        end
    end

    a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stt_pkg::MODE_IDLE) |-> (wlen_reg == '0 && window_reg == '0))
        else $error("word state left over outside an identifier");

    a_ident_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stt_pkg::MODE_IDENT) |->
            (wlen_reg != '0 && wlen_reg <= WLEN_LIMIT + 1'b1))
        else $error("identifier word length out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.last && push.second.last &&
                                  push.first.kind != stt_pkg::KIND_EOF))
        else $error("token pair out of order");

endmodule

@@ design/stt_token_fifo.sv @@
module stt_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  stt_pkg::push_t  push,
    input  logic            pop,
    output logic            room,
    output logic            not_empty,
    output stt_pkg::token_t head
);

    stt_pkg::token_t mem [stt_pkg::FIFO_DEPTH];

    logic [stt_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::FIFO_COUNT_BITS-1:0] count_reg, count_next;
    logic [stt_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_plus;

    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + stt_pkg::FIFO_PTR_BITS'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + stt_pkg::FIFO_COUNT_BITS'(push.count)
                      - stt_pkg::FIFO_COUNT_BITS'(pop);
        // Accept a byte only while a pair of tokens is sure to fit
        room      = (count_reg <= stt_pkg::FIFO_COUNT_BITS'(stt_pkg::FIFO_DEPTH - 2));
        not_empty = (count_reg != '0);
        head      = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push.count) - 32'(pop)) <= stt_pkg::FIFO_DEPTH)
        else $error("token queue overflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        stt_pkg::FIFO_PTR_BITS'(wr_ptr_reg - rd_ptr_reg) ==
            stt_pkg::FIFO_PTR_BITS'(count_reg))
        else $error("token queue pointers disagree with count");

endmodule

@@ design/source_text_tokenizer_unit.sv @@
// Source text tokenizer: takes one source byte per item on the input channel and
// returns tokens (kind, start offset, length, last-of-run flag) on the output channel.
// A byte is accepted every cycle while the four-entry token queue holds two tokens or
// fewer; each byte raises zero, one or two tokens, which are written into the queue as
// the byte is accepted and reach the output in order. A byte raises two tokens only
// when it closes a run that an earlier byte opened, so while the output is taken every
// cycle the queue never holds more than two tokens and bytes go in at one per cycle;
// stalls on the output hold the input once the queue has more than two tokens waiting.
// The two keyword registers (default "let" and "fn") are written through the cfg port;
// the user writes them only while no item is in flight; the block does not enforce it.
module source_text_tokenizer_unit #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_BYTES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           char_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3:0]                           token_kind,
    output logic [15:0]                          start_offset,
    output logic [15:0]                          token_length,
    output logic                                 last_of_run,
    input  logic                                 cfg_write,
    input  logic [stt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [stt_pkg::KEYWORD_REG_BITS-1:0] cfg_data
);

    stt_pkg::push_t  push;
    stt_pkg::token_t head;
    logic            room;
    logic            not_empty;

    stt_scanner #(
        .POSITION_BITS(POSITION_BITS),
        .KEYWORD_BYTES(KEYWORD_BYTES)
    ) u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_valid && room),
        .char_byte(char_byte),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push)
    );

    stt_token_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (not_empty && out_ready),
        .room     (room),
        .not_empty(not_empty),
        .head     (head)
    );

    assign in_ready     = room;
    assign out_valid    = not_empty;
    assign token_kind   = head.kind;
    assign start_offset = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule
